// ===== src/jsu_pkg.sv =====
package jsu_pkg;

  // results per input byte, at most one four-byte utf-8 sequence
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd1;
  localparam logic [3:0] ERR_NUL          = 4'd2;
  localparam logic [3:0] ERR_CONTROL      = 4'd3;
  localparam logic [3:0] ERR_ESCAPE_CUT   = 4'd4;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
  localparam logic [3:0] ERR_UNPAIRED_HI  = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd8;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd9;
  localparam logic [3:0] ERR_U0000        = 4'd10;

  // group of results produced by one input byte
  typedef struct packed {
    logic [CountW-1:0]           count;
    logic [1:0]                  kind;
    logic [3:0]                  err;
    logic [MaxResults-1:0][7:0]  bytes;
  } burst_t;

endpackage

// ===== src/jsu_in_if.sv =====
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== src/jsu_out_if.sv =====
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

// ===== src/json_string_unescape_utf8_core.sv =====
// JSON string body decoder. Bytes of a string body (after the opening quote)
// enter on in_i, one per transaction, with end_of_input marking a source that
// ran out; decoded UTF-8 bytes, an end result at the closing quote, or an error
// result leave on out_o, with last set on the final result of each input byte.
// Bytes pass an input register, then the decoder into a result register, from
// which the first result of a byte is presented on out_o. One byte is taken
// per cycle as long as each byte yields at most one result and out_o is ready;
// a \u escape that completes into a multi-byte UTF-8 sequence holds the input
// until the last of its bytes is being taken, since out_o carries one result
// per cycle. Bytes that only advance an escape produce no result. After an
// end or an error the decoder is back in plain text, ready for the next string
// body.
module json_string_unescape_utf8_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            eoi_q;
  logic            adv;
  logic            emit_free;
  jsu_pkg::burst_t burst;

  // byte moves from the input register into the result register
  assign adv        = in_vld_q && emit_free;
  assign in_i.ready = !in_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
      eoi_q     <= in_i.end_of_input;
    end
  end

  // escape and utf-8 decoding
  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .in_byte_i (in_byte_q),
    .eoi_i     (eoi_q),
    .burst_o   (burst)
  );

  // result register and burst serializer
  jsu_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .burst_i (burst),
    .free_o  (emit_free),
    .out_o   (out_o)
  );

endmodule

// ===== src/jsu_decode.sv =====
module jsu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      in_byte_i,
  input  logic            eoi_i,
  output jsu_pkg::burst_t burst_o
);

  // decoder phases
  localparam logic [2:0] PH_PLAIN   = 3'd0;
  localparam logic [2:0] PH_ESCAPE  = 3'd1;
  localparam logic [2:0] PH_HEX_HI  = 3'd2;
  localparam logic [2:0] PH_WANT_BS = 3'd3;
  localparam logic [2:0] PH_WANT_U  = 3'd4;
  localparam logic [2:0] PH_HEX_LO  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  seen_q, seen_d;
  logic [15:0] accum_q, accum_d;
  logic [9:0]  held_q, held_d;

  logic [4:0]  hex;
  logic [15:0] accum_n;
  logic [20:0] pair_cp;
  jsu_pkg::burst_t burst;

  // ascii hex digit: valid flag and value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // utf-8 form of a code point
  function automatic jsu_pkg::burst_t utf8(input logic [20:0] cp);
    jsu_pkg::burst_t b;
    b = '0;
    b.kind = jsu_pkg::KIND_BYTE;
    b.err  = jsu_pkg::ERR_NONE;
    if (cp <= 21'h7F) begin
      b.count    = jsu_pkg::CountW'(1);
      b.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      b.count    = jsu_pkg::CountW'(2);
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      b.count    = jsu_pkg::CountW'(3);
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      b.count    = jsu_pkg::CountW'(4);
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

  // single error result
  function automatic jsu_pkg::burst_t error_burst(input logic [3:0] code);
    jsu_pkg::burst_t b;
    b       = '0;
    b.count = jsu_pkg::CountW'(1);
    b.kind  = jsu_pkg::KIND_ERROR;
    b.err   = code;
    return b;
  endfunction

  assign hex     = eoi_i ? 5'd0 : hex_value(in_byte_i);
  assign accum_n = {accum_q[11:0], hex[3:0]};
  assign pair_cp = 21'h10000 + {1'b0, held_q, accum_n[9:0]};

  // next state and results of one byte
  always_comb begin
    phase_d = phase_q;
    seen_d  = seen_q;
    accum_d = accum_q;
    held_d  = held_q;
    burst   = '0;
    case (phase_q)
      PH_PLAIN: begin
        if (eoi_i) begin
          burst = error_burst(jsu_pkg::ERR_UNTERMINATED);
        end else if (in_byte_i == "\"") begin
          burst.count = jsu_pkg::CountW'(1);
          burst.kind  = jsu_pkg::KIND_END;
        end else if (in_byte_i == 8'h00) begin
          burst = error_burst(jsu_pkg::ERR_NUL);
        end else if (in_byte_i < 8'h20) begin
          burst = error_burst(jsu_pkg::ERR_CONTROL);
        end else if (in_byte_i == "\\") begin
          phase_d = PH_ESCAPE;
        end else begin
          burst.count    = jsu_pkg::CountW'(1);
          burst.bytes[0] = in_byte_i;
        end
      end
      PH_ESCAPE: begin
        phase_d = PH_PLAIN;
        burst.count = jsu_pkg::CountW'(1);
        if (eoi_i) begin
          burst = error_burst(jsu_pkg::ERR_ESCAPE_CUT);
        end else begin
          case (in_byte_i)
            "\"":    burst.bytes[0] = 8'h22;
            "\\":    burst.bytes[0] = 8'h5C;
            "/":     burst.bytes[0] = 8'h2F;
            "b":     burst.bytes[0] = 8'h08;
            "f":     burst.bytes[0] = 8'h0C;
            "n":     burst.bytes[0] = 8'h0A;
            "r":     burst.bytes[0] = 8'h0D;
            "t":     burst.bytes[0] = 8'h09;
            "u": begin
              burst   = '0;
              phase_d = PH_HEX_HI;
              seen_d  = 2'd0;
              accum_d = 16'd0;
            end
            default: burst = error_burst(jsu_pkg::ERR_BAD_ESCAPE);
          endcase
        end
      end
      PH_HEX_HI, PH_HEX_LO: begin
        if (!hex[4]) begin
          burst = error_burst(jsu_pkg::ERR_BAD_HEX);
        end else if (seen_q != 2'd3) begin
          seen_d  = seen_q + 2'd1;
          accum_d = accum_n;
        end else if (phase_q == PH_HEX_HI) begin
          seen_d = 2'd0;
          if (accum_n >= 16'hD800 && accum_n <= 16'hDBFF) begin
            held_d  = accum_n[9:0];
            accum_d = 16'd0;
            phase_d = PH_WANT_BS;
          end else if (accum_n >= 16'hDC00 && accum_n <= 16'hDFFF) begin
            burst = error_burst(jsu_pkg::ERR_LONE_LOW);
          end else if (accum_n == 16'h0000) begin
            burst = error_burst(jsu_pkg::ERR_U0000);
          end else begin
            burst = utf8({5'd0, accum_n});
          end
        end else begin
          seen_d = 2'd0;
          if (accum_n < 16'hDC00 || accum_n > 16'hDFFF) begin
            burst = error_burst(jsu_pkg::ERR_BAD_LOW);
          end else begin
            burst = utf8(pair_cp);
          end
        end
      end
      PH_WANT_BS: begin
        if (eoi_i || in_byte_i != "\\") begin
          burst = error_burst(jsu_pkg::ERR_UNPAIRED_HI);
        end else begin
          phase_d = PH_WANT_U;
        end
      end
      PH_WANT_U: begin
        if (eoi_i || in_byte_i != "u") begin
          burst = error_burst(jsu_pkg::ERR_UNPAIRED_HI);
        end else begin
          phase_d = PH_HEX_LO;
          seen_d  = 2'd0;
          accum_d = 16'd0;
        end
      end
      default: begin
        phase_d = PH_PLAIN;
      end
    endcase
    // any result ends the current string or escape
    if (burst.count != '0) begin
      phase_d = PH_PLAIN;
      seen_d  = 2'd0;
      accum_d = 16'd0;
      held_d  = 10'd0;
    end
  end

  assign burst_o = burst;

  // decoder state, advanced once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      seen_q  <= 2'd0;
      accum_q <= 16'd0;
      held_q  <= 10'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      accum_q <= accum_d;
      held_q  <= held_d;
    end
  end

  // a hex digit count only runs inside a \u escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q != 2'd0) |-> (phase_q == PH_HEX_HI || phase_q == PH_HEX_LO))
    else $error("hex digit count outside a unicode escape");

  // a held high surrogate only waits for its low half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != 10'd0) |-> (phase_q == PH_WANT_BS || phase_q == PH_WANT_U ||
                           phase_q == PH_HEX_LO))
    else $error("high surrogate held outside a pair");

  // a byte that produces results leaves the decoder in plain text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && burst.count != '0) |=> (phase_q == PH_PLAIN))
    else $error("decoder did not restart after a result");

endmodule

// ===== src/jsu_emit.sv =====
module jsu_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jsu_pkg::burst_t   burst_i,
  output logic              free_o,
  jsu_out_if.source         out_o
);

  logic [jsu_pkg::CountW-1:0]          cnt_q;
  logic [jsu_pkg::IdxW-1:0]            idx_q;
  logic [1:0]                          kind_q;
  logic [3:0]                          err_q;
  logic [jsu_pkg::MaxResults-1:0][7:0] bytes_q;
  logic                                take;

  assign take   = out_o.valid && out_o.ready;
  assign free_o = (cnt_q == '0) || (cnt_q == jsu_pkg::CountW'(1) && out_o.ready);

  // result register, one result per transaction
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.kind       = kind_q;
  assign out_o.error_code = err_q;
  assign out_o.out_byte   = bytes_q[idx_q];
  assign out_o.last       = (cnt_q == jsu_pkg::CountW'(1));

  // burst count and read position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i && burst_i.count != '0) begin
      cnt_q <= burst_i.count;
      idx_q <= '0;
    end else if (take) begin
      cnt_q <= cnt_q - jsu_pkg::CountW'(1);
      idx_q <= idx_q + jsu_pkg::IdxW'(1);
    end
  end

  // burst payload
  always_ff @(posedge clk_i) begin
    if (load_i && burst_i.count != '0) begin
      kind_q  <= burst_i.kind;
      err_q   <= burst_i.err;
      bytes_q <= burst_i.bytes;
    end
  end

  // end and error results stand alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != jsu_pkg::KIND_BYTE) |-> out_o.last)
    else $error("end or error result is not the last one");

  // a burst never exceeds a four-byte sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= jsu_pkg::CountW'(jsu_pkg::MaxResults))
    else $error("result count overflow");

  // a stalled result keeps its place in the burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> ($stable(cnt_q) && $stable(idx_q)))
    else $error("burst position moved while stalled");

endmodule
